// File: hdl/cbr_pkg.sv
// Shared types, constants and helpers for the complex box reflection unit.
`timescale 1ns / 1ps
package cbr_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int AXES           = 3;
   localparam int LEN_W          = 31;
   localparam int COORD_W        = 32;
   localparam int KIND_W         = 2;
   localparam int WIDE_W         = 35;
   localparam int CSR_IDX_W      = 2;
   localparam int OUT_DEPTH      = 4;
   localparam int OUT_PTR_W      = 2;
   localparam int OUT_FILL_W     = 3;

   localparam logic [LEN_W-1:0] BOX_LEN_RESET = 31'd6553600;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEN_Z = 2'd2;

   localparam logic [KIND_W-1:0] KIND_CENTER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROTEIN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SITE    = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      coord_type [AXES-1:0]   pos;
   } point_type;

   typedef struct packed {
      logic [AXES-1:0]        hit;
      coord_type [AXES-1:0]   shift;
   } run_info_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      coord_type [AXES-1:0]   pos;
      logic [AXES-1:0]        moved;
      logic                   last;
   } result_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   function automatic wide_type widen(input coord_type c);
      widen = {{(WIDE_W-COORD_W){c[COORD_W-1]}}, c};
   endfunction

   function automatic coord_type sat32(input wide_type v);
      logic [WIDE_W-COORD_W:0] head;
      head = v[WIDE_W-1:COORD_W-1];
      if ((&head) || !(|head)) begin
         sat32 = v[COORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat32 = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction
endpackage

// File: hdl/cbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/cbr_run_queue.sv
// Two-entry queue of finished run descriptors between front and back.
`timescale 1ns / 1ps
module cbr_run_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic [WIDTH-1:0] entry_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && valid) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(push) - 2'(pop && valid);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign valid = (fill_ff != 2'd0);
   assign data  = entry_ff[rd_ptr_ff];
endmodule

// File: hdl/cbr_front.sv
// Front end: box registers, point intake, wall tests, shift accumulation, RAM fill.
`timescale 1ns / 1ps
module cbr_front #(
   parameter int MAX_POINTS = cbr_pkg::MAX_POINTS_DEF,
   parameter int IDX_W      = $clog2(MAX_POINTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbr_pkg::LEN_W-1:0]     csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [cbr_pkg::KIND_W-1:0]    req_point_kind,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_z,
   input  logic [cbr_pkg::LEN_W-1:0]     req_radius,
   input  logic                          req_last_point,
   output logic                          wr_en,
   output logic [IDX_W:0]                wr_addr,
   output cbr_pkg::point_type            wr_data,
   output logic                          desc_valid,
   output logic                          desc_bank,
   output logic [IDX_W:0]                desc_count,
   output cbr_pkg::run_info_type         desc_info,
   input  cbr_pkg::bank_free_type        bank_free
);
   import cbr_pkg::*;

   localparam int CNT_W = IDX_W + 1;

   logic [AXES-1:0][LEN_W-1:0] box_len_ff, box_len_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [AXES-1:0]            sphere_ff, sphere_in;
   logic [AXES-1:0]            hit_ff, hit_in;
   coord_type                  shift_ff [AXES];
   coord_type                  shift_in [AXES];
   logic                       bank_ff, bank_in;
   logic [1:0]                 busy_ff, busy_in;

   logic                       accept;
   logic                       stored;
   coord_type                  pos [AXES];
   wide_type                   p2 [AXES];
   wide_type                   len_w [AXES];
   wide_type                   r2;
   logic [AXES-1:0]            sphere_hit, up, dn;
   coord_type                  cand [AXES];

   always_comb begin
      box_len_in = box_len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BOX_LEN_X: box_len_in[0] = csr_wdata;
            CSR_BOX_LEN_Y: box_len_in[1] = csr_wdata;
            CSR_BOX_LEN_Z: box_len_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = busy_ff[bank_ff];
   assign accept   = req_push && !req_full;
   assign stored   = accept && (count_ff < CNT_W'(MAX_POINTS));

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;
   assign r2 = {{(WIDE_W-LEN_W-1){1'b0}}, req_radius, 1'b0};

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         p2[a]    = widen(pos[a]) <<< 1;
         len_w[a] = {{(WIDE_W-LEN_W){1'b0}}, box_len_ff[a]};
         sphere_hit[a] = ((p2[a] + r2) > len_w[a]) || ((p2[a] - r2) < -len_w[a]);
         up[a]   = p2[a] > len_w[a];
         dn[a]   = p2[a] < -len_w[a];
         cand[a] = sat32(up[a] ? (len_w[a] - p2[a]) : (-len_w[a] - p2[a]));
      end
   end

   always_comb begin
      count_in  = count_ff;
      sphere_in = sphere_ff;
      hit_in    = hit_ff;
      shift_in  = shift_ff;
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      if (stored) begin
         if (count_ff == '0) begin
            sphere_in = sphere_hit;
         end else if (req_point_kind == KIND_SITE) begin
            for (int a = 0; a < AXES; a++) begin
               if (sphere_ff[a] && (up[a] || dn[a])) begin
                  hit_in[a] = 1'b1;
                  if (up[a] ? (cand[a] < shift_ff[a]) : (cand[a] > shift_ff[a])) begin
                     shift_in[a] = cand[a];
                  end
               end
            end
         end
         count_in = count_ff + CNT_W'(1);
      end

      desc_valid = accept && req_last_point;
      desc_bank  = bank_ff;
      desc_count = count_in;
      desc_info.hit = hit_in;
      for (int a = 0; a < AXES; a++) begin
         desc_info.shift[a] = shift_in[a];
      end

      if (desc_valid) begin
         count_in  = '0;
         sphere_in = '0;
         hit_in    = '0;
         for (int a = 0; a < AXES; a++) begin
            shift_in[a] = '0;
         end
         bank_in          = ~bank_ff;
         busy_in[bank_ff] = 1'b1;
      end
      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end
   end

   always_comb begin
      wr_en        = stored;
      wr_addr      = {bank_ff, count_ff[IDX_W-1:0]};
      wr_data.kind = req_point_kind;
      for (int a = 0; a < AXES; a++) begin
         wr_data.pos[a] = pos[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_len_ff <= {AXES{BOX_LEN_RESET}};
         count_ff   <= '0;
         sphere_ff  <= '0;
         hit_ff     <= '0;
         for (int a = 0; a < AXES; a++) begin
            shift_ff[a] <= '0;
         end
         bank_ff    <= 1'b0;
         busy_ff    <= '0;
      end else begin
         box_len_ff <= box_len_in;
         count_ff   <= count_in;
         sphere_ff  <= sphere_in;
         hit_ff     <= hit_in;
         shift_ff   <= shift_in;
         bank_ff    <= bank_in;
         busy_ff    <= busy_in;
      end
   end
endmodule

// File: hdl/cbr_back.sv
// Back end: walks a stored run through the RAM, applies the shift, queues results.
`timescale 1ns / 1ps
module cbr_back #(
   parameter int IDX_W = $clog2(cbr_pkg::MAX_POINTS_DEF)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   desc_valid,
   input  logic                   desc_bank,
   input  logic [IDX_W:0]         desc_count,
   input  cbr_pkg::run_info_type  desc_info,
   output logic                   desc_pop,
   output logic                   rd_en,
   output logic [IDX_W:0]         rd_addr,
   input  cbr_pkg::point_type     rd_data,
   output cbr_pkg::bank_free_type bank_free,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output cbr_pkg::result_type    rsp_beat
);
   import cbr_pkg::*;

   localparam int CNT_W = IDX_W + 1;

   back_state_type         state_ff, state_in;
   logic                   bank_ff, bank_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   run_info_type           info_ff, info_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_last_ff, s1_last_in;
   run_info_type           s1_info_ff, s1_info_in;

   result_type             fifo_ff [OUT_DEPTH];
   result_type             fifo_in [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_FILL_W-1:0]  fill_ff, fill_in;

   logic                   credit;
   logic                   is_last;
   logic                   fifo_pop;
   result_type             res;

   assign credit  = (fill_ff + OUT_FILL_W'(s1_valid_ff)) < OUT_FILL_W'(OUT_DEPTH);
   assign is_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign rd_addr = {bank_ff, idx_ff};

   always_comb begin
      state_in  = state_ff;
      bank_in   = bank_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      info_in   = info_ff;
      desc_pop  = 1'b0;
      rd_en     = 1'b0;
      bank_free = '0;
      case (state_ff)
         BACK_IDLE: begin
            if (desc_valid) begin
               desc_pop = 1'b1;
               bank_in  = desc_bank;
               count_in = desc_count;
               info_in  = desc_info;
               idx_in   = '0;
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            if (credit) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + IDX_W'(1);
               if (is_last) begin
                  bank_free.valid = 1'b1;
                  bank_free.bank  = bank_ff;
                  state_in        = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
      s1_valid_in = rd_en;
      s1_last_in  = is_last;
      s1_info_in  = info_ff;
   end

   always_comb begin
      res.kind  = rd_data.kind;
      res.moved = s1_info_ff.hit;
      res.last  = s1_last_ff;
      for (int a = 0; a < AXES; a++) begin
         res.pos[a] = s1_info_ff.hit[a] ?
                      sat32(widen(rd_data.pos[a]) + widen(s1_info_ff.shift[a])) :
                      rd_data.pos[a];
      end
   end

   assign fifo_pop = rsp_pop && !rsp_empty;

   always_comb begin
      fifo_in   = fifo_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (s1_valid_ff) begin
         fifo_in[wr_ptr_ff] = res;
         wr_ptr_in = wr_ptr_ff + OUT_PTR_W'(1);
      end
      if (fifo_pop) begin
         rd_ptr_in = rd_ptr_ff + OUT_PTR_W'(1);
      end
      fill_in = fill_ff + OUT_FILL_W'(s1_valid_ff) - OUT_FILL_W'(fifo_pop);
   end

   always_ff @(posedge clock) begin
      bank_ff    <= bank_in;
      idx_ff     <= idx_in;
      count_ff   <= count_in;
      info_ff    <= info_in;
      s1_last_ff <= s1_last_in;
      s1_info_ff <= s1_info_in;
      fifo_ff    <= fifo_in;
      if (reset) begin
         state_ff    <= BACK_IDLE;
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
      end
   end

   assign rsp_empty = (fill_ff == '0);
   assign rsp_beat  = fifo_ff[rd_ptr_ff];
endmodule

// File: hdl/complex_box_reflection_unit.sv
// Top level of the complex box reflection unit: front, run queue, point RAM, back.
// Input takes one point per cycle while req_full is low; the point RAM has two banks,
// so one run loads while the previous run is emitted. req_full is high while both
// banks hold runs. Output: one result per cycle while the output queue has room,
// paced by the single read port of the point RAM.
// Reset (synchronous): clears run state, bank flags and queues, box lengths to 100.0.
`timescale 1ns / 1ps
module complex_box_reflection_unit #(
   parameter int MAX_POINTS = cbr_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [cbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbr_pkg::LEN_W-1:0]          csr_wdata,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [cbr_pkg::KIND_W-1:0]         req_point_kind,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [cbr_pkg::COORD_W-1:0] req_pos_z,
   input  logic [cbr_pkg::LEN_W-1:0]          req_radius,
   input  logic                               req_last_point,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [cbr_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic signed [cbr_pkg::COORD_W-1:0] rsp_new_x,
   output logic signed [cbr_pkg::COORD_W-1:0] rsp_new_y,
   output logic signed [cbr_pkg::COORD_W-1:0] rsp_new_z,
   output logic [cbr_pkg::AXES-1:0]           rsp_moved_axes,
   output logic                               rsp_last_out
);
   import cbr_pkg::*;

   localparam int IDX_W     = $clog2(MAX_POINTS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int RAM_DEPTH = 2 * (1 << IDX_W);
   localparam int DESC_W    = 1 + CNT_W + $bits(run_info_type);

   logic               wr_en;
   logic [IDX_W:0]     wr_addr;
   point_type          wr_data;
   logic               rd_en;
   logic [IDX_W:0]     rd_addr;
   point_type          rd_data;

   logic               front_desc_valid;
   logic               front_desc_bank;
   logic [CNT_W-1:0]   front_desc_count;
   run_info_type       front_desc_info;

   logic               q_valid;
   logic               q_pop;
   logic [DESC_W-1:0]  q_data;
   logic               back_desc_bank;
   logic [CNT_W-1:0]   back_desc_count;
   run_info_type       back_desc_info;

   bank_free_type      bank_free;
   result_type         rsp_beat;

   cbr_front #(
      .MAX_POINTS (MAX_POINTS),
      .IDX_W      (IDX_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_point_kind (req_point_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_radius     (req_radius),
      .req_last_point (req_last_point),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .desc_valid     (front_desc_valid),
      .desc_bank      (front_desc_bank),
      .desc_count     (front_desc_count),
      .desc_info      (front_desc_info),
      .bank_free      (bank_free)
   );

   cbr_run_queue #(
      .WIDTH (DESC_W)
   ) u_run_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_desc_valid),
      .push_data ({front_desc_bank, front_desc_count, front_desc_info}),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_data)
   );

   assign {back_desc_bank, back_desc_count, back_desc_info} = q_data;

   cbr_ram #(
      .WIDTH ($bits(point_type)),
      .DEPTH (RAM_DEPTH)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cbr_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (q_valid),
      .desc_bank  (back_desc_bank),
      .desc_count (back_desc_count),
      .desc_info  (back_desc_info),
      .desc_pop   (q_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .bank_free  (bank_free),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_out_kind   = rsp_beat.kind;
   assign rsp_new_x      = rsp_beat.pos[0];
   assign rsp_new_y      = rsp_beat.pos[1];
   assign rsp_new_z      = rsp_beat.pos[2];
   assign rsp_moved_axes = rsp_beat.moved;
   assign rsp_last_out   = rsp_beat.last;
endmodule

// File: hdl/cbr_checker.sv
// Port-level assertions for the complex box reflection unit, bound to the top level.
`timescale 1ns / 1ps
module cbr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic [cbr_pkg::KIND_W-1:0]         rsp_out_kind,
   input logic signed [cbr_pkg::COORD_W-1:0] rsp_new_x,
   input logic signed [cbr_pkg::COORD_W-1:0] rsp_new_y,
   input logic signed [cbr_pkg::COORD_W-1:0] rsp_new_z,
   input logic [cbr_pkg::AXES-1:0]           rsp_moved_axes,
   input logic                               rsp_last_out
);
   import cbr_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_kind) &&
         $stable(rsp_new_x) && $stable(rsp_new_y) && $stable(rsp_new_z) &&
         $stable(rsp_moved_axes) && $stable(rsp_last_out)))
      else $error("stalled result beat changed");

   a_moved_per_run: assert property (@(posedge clock) disable iff (reset)
      ((rsp_pop && !rsp_empty && !rsp_last_out) ##1 !rsp_empty) |->
         (rsp_moved_axes == $past(rsp_moved_axes)))
      else $error("moved axes changed inside a run");
endmodule

bind complex_box_reflection_unit cbr_checker u_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the complex box reflection unit.
`timescale 1ns / 1ps
module testbench;
   import cbr_pkg::*;

   localparam int STASH_DEPTH = MAX_POINTS_DEF;
   localparam int IDLE_PCT = 27;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_MAX = 10;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam logic [LEN_W-1:0] LEN_MIN = 31'd1;
   localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;
   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   typedef struct {
      logic [KIND_W-1:0] kind;
      coord_type x;
      coord_type y;
      coord_type z;
      logic [LEN_W-1:0] radius;
      logic last;
   } sample_point_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      coord_type x;
      coord_type y;
      coord_type z;
      logic [AXES-1:0] moved;
      logic last;
   } moved_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BOX_LEN_X;
   logic [LEN_W-1:0] csr_wdata = '0;
   logic req_push = 1'b0;
   logic req_full;
   logic [KIND_W-1:0] req_point_kind = KIND_CENTER;
   coord_type req_pos_x = '0;
   coord_type req_pos_y = '0;
   coord_type req_pos_z = '0;
   logic [LEN_W-1:0] req_radius = '0;
   logic req_last_point = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [KIND_W-1:0] rsp_out_kind;
   coord_type rsp_new_x;
   coord_type rsp_new_y;
   coord_type rsp_new_z;
   logic [AXES-1:0] rsp_moved_axes;
   logic rsp_last_out;

   sample_point_type point_backlog [$];
   moved_point_type moved_points_due [$];
   logic req_taken = 1'b0;
   bit steady_flow = 1'b0;
   int points_queued = 0;
   int points_accepted = 0;
   int mismatches = 0;
   int stall_cycles = 0;

   logic [LEN_W-1:0] box_len [AXES];
   logic [KIND_W-1:0] stash_kind [STASH_DEPTH];
   longint stash_pos [STASH_DEPTH][AXES];
   int stash_fill;
   logic [AXES-1:0] sphere_out;
   logic [AXES-1:0] wall_hit;
   longint shift_acc [AXES];

   complex_box_reflection_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_push(req_push),
      .req_full(req_full),
      .req_point_kind(req_point_kind),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_radius(req_radius),
      .req_last_point(req_last_point),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_kind(rsp_out_kind),
      .rsp_new_x(rsp_new_x),
      .rsp_new_y(rsp_new_y),
      .rsp_new_z(rsp_new_z),
      .rsp_moved_axes(rsp_moved_axes),
      .rsp_last_out(rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(input longint v);
      if (v > longint'(COORD_MAX)) begin
         return longint'(COORD_MAX);
      end
      if (v < longint'(COORD_MIN)) begin
         return longint'(COORD_MIN);
      end
      return v;
   endfunction

   function automatic void clear_run();
      stash_fill = 0;
      sphere_out = '0;
      wall_hit = '0;
      for (int a = 0; a < AXES; a++) begin
         shift_acc[a] = 0;
      end
   endfunction

   // Fold one accepted point into the run; on the last point emit the moved run.
   function automatic void absorb_point(input sample_point_type pt);
      longint p [AXES];
      longint q [AXES];
      longint len;
      longint r;
      longint cand;
      moved_point_type mp;
      p[0] = longint'(pt.x);
      p[1] = longint'(pt.y);
      p[2] = longint'(pt.z);
      r = longint'({1'b0, pt.radius});
      if (stash_fill < STASH_DEPTH) begin
         for (int a = 0; a < AXES; a++) begin
            len = longint'({1'b0, box_len[a]});
            if (stash_fill == 0) begin
               if (2 * p[a] + 2 * r > len || 2 * p[a] - 2 * r < -len) begin
                  sphere_out[a] = 1'b1;
               end
            end else if (pt.kind == KIND_SITE && sphere_out[a]) begin
               if (2 * p[a] > len) begin
                  cand = clamp32(len - 2 * p[a]);
                  wall_hit[a] = 1'b1;
                  if (cand < shift_acc[a]) begin
                     shift_acc[a] = cand;
                  end
               end else if (2 * p[a] < -len) begin
                  cand = clamp32(-len - 2 * p[a]);
                  wall_hit[a] = 1'b1;
                  if (cand > shift_acc[a]) begin
                     shift_acc[a] = cand;
                  end
               end
            end
            stash_pos[stash_fill][a] = p[a];
         end
         stash_kind[stash_fill] = pt.kind;
         stash_fill++;
      end
      if (pt.last) begin
         for (int i = 0; i < stash_fill; i++) begin
            for (int a = 0; a < AXES; a++) begin
               q[a] = stash_pos[i][a];
               if (wall_hit[a]) begin
                  q[a] = clamp32(q[a] + shift_acc[a]);
               end
            end
            mp.kind = stash_kind[i];
            mp.x = q[0][COORD_W-1:0];
            mp.y = q[1][COORD_W-1:0];
            mp.z = q[2][COORD_W-1:0];
            mp.moved = wall_hit;
            mp.last = (i + 1 == stash_fill);
            moved_points_due.push_back(mp);
         end
         clear_run();
      end
   endfunction

   function automatic coord_type pick_coord(input logic [LEN_W-1:0] len);
      longint half;
      longint v;
      half = longint'({1'b0, len}) / 2;
      case ($urandom_range(9))
         0, 1: v = longint'($signed($urandom));
         2: begin
            case ($urandom_range(3))
               0: v = longint'(COORD_MAX);
               1: v = longint'(COORD_MIN);
               2: v = 0;
               default: v = -1;
            endcase
         end
         3, 4, 5, 6: begin
            v = half + longint'($urandom_range(1 << 20)) - longint'(1 << 19);
            if ($urandom_range(1)) begin
               v = -v;
            end
         end
         default: v = longint'($urandom_range(len)) - half;
      endcase
      v = clamp32(v);
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] pick_radius(input logic [LEN_W-1:0] len);
      case ($urandom_range(5))
         0: return '0;
         1: return LEN_MAX;
         2: return LEN_W'($urandom);
         3, 4: return LEN_W'($urandom_range(len));
         default: return LEN_W'($urandom_range(len / 8));
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         return KIND_SITE;
      end
      if (roll < 80) begin
         return KIND_PROTEIN;
      end
      if (roll < 90) begin
         return KIND_CENTER;
      end
      return KIND_SPARE;
   endfunction

   task automatic add_point(input logic [KIND_W-1:0] kind, input coord_type x,
                            input coord_type y, input coord_type z,
                            input logic [LEN_W-1:0] radius, input logic last);
      sample_point_type pt;
      pt.kind = kind;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      pt.radius = radius;
      pt.last = last;
      point_backlog.push_back(pt);
      points_queued++;
   endtask

   task automatic queue_run(input int n_points);
      logic [KIND_W-1:0] kind;
      for (int i = 0; i < n_points; i++) begin
         if (i == 0) begin
            kind = KIND_CENTER;
            if ($urandom_range(9) == 0) begin
               kind = KIND_W'($urandom_range(3));
            end
         end else begin
            kind = pick_kind();
         end
         add_point(kind, pick_coord(box_len[0]), pick_coord(box_len[1]),
                   pick_coord(box_len[2]), pick_radius(box_len[0]), i == n_points - 1);
      end
   endtask

   task automatic settle_block();
      while (points_accepted != points_queued || moved_points_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_box_len(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      box_len[idx] = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] len_x, input logic [LEN_W-1:0] len_y,
                            input logic [LEN_W-1:0] len_z, input bit long_run,
                            input bit steady);
      int added;
      int n_points;
      int roll;
      settle_block();
      write_box_len(CSR_BOX_LEN_X, len_x);
      write_box_len(CSR_BOX_LEN_Y, len_y);
      write_box_len(CSR_BOX_LEN_Z, len_z);
      steady_flow = steady;
      added = 0;
      while (added < 27) begin
         roll = $urandom_range(19);
         if (roll == 0) begin
            n_points = 1;
         end else if (roll < 16) begin
            n_points = $urandom_range(2, 8);
         end else begin
            n_points = $urandom_range(9, 20);
         end
         queue_run(n_points);
         added += n_points;
      end
      if (long_run) begin
         queue_run(STASH_DEPTH + $urandom_range(2, 6));
      end
      settle_block();
      steady_flow = 1'b0;
   endtask

   always @(negedge clock) begin : driver
      sample_point_type nxt;
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop <= 1'b0;
      end else begin
         if (!req_push || req_taken) begin
            if (point_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = point_backlog.pop_front();
               req_point_kind <= nxt.kind;
               req_pos_x <= nxt.x;
               req_pos_y <= nxt.y;
               req_pos_z <= nxt.z;
               req_radius <= nxt.radius;
               req_last_point <= nxt.last;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : monitor
      sample_point_type seen;
      moved_point_type want;
      if (reset) begin
         req_taken <= 1'b0;
         stall_cycles = 0;
      end else begin
         req_taken <= req_push && !req_full;
         if (req_push && !req_full) begin
            seen.kind = req_point_kind;
            seen.x = req_pos_x;
            seen.y = req_pos_y;
            seen.z = req_pos_z;
            seen.radius = req_radius;
            seen.last = req_last_point;
            absorb_point(seen);
            points_accepted++;
         end
         if (rsp_pop && !rsp_empty) begin
            if (moved_points_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("unexpected beat: kind=%0d x=%h y=%h z=%h moved=%b last=%b",
                           rsp_out_kind, rsp_new_x, rsp_new_y, rsp_new_z,
                           rsp_moved_axes, rsp_last_out);
               end
            end else begin
               want = moved_points_due.pop_front();
               if (rsp_out_kind !== want.kind || rsp_new_x !== want.x ||
                   rsp_new_y !== want.y || rsp_new_z !== want.z ||
                   rsp_moved_axes !== want.moved || rsp_last_out !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch: expected kind=%0d x=%h y=%h z=%h moved=%b last=%b",
                              want.kind, want.x, want.y, want.z, want.moved, want.last);
                     $display("          actual   kind=%0d x=%h y=%h z=%h moved=%b last=%b",
                              rsp_out_kind, rsp_new_x, rsp_new_y, rsp_new_z,
                              rsp_moved_axes, rsp_last_out);
                  end
               end
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : sequencer
      for (int a = 0; a < AXES; a++) begin
         box_len[a] = BOX_LEN_RESET;
      end
      clear_run();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // lone center
      add_point(KIND_CENTER, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1);
      // huge sphere; sites beyond both walls, on the wall, and stray kinds
      add_point(KIND_CENTER, 32'sd0, 32'sd0, 32'sd0, LEN_MAX, 1'b0);
      add_point(KIND_PROTEIN, 32'sd65536, 32'sd131072, 32'sd196608, 31'd0, 1'b0);
      add_point(KIND_SITE, COORD_MAX, COORD_MIN, 32'sd3276801, 31'd0, 1'b0);
      add_point(KIND_SITE, 32'sd3276800, -32'sd3276801, 32'sd0, LEN_MAX, 1'b0);
      add_point(KIND_CENTER, COORD_MAX, COORD_MAX, COORD_MAX, 31'd0, 1'b0);
      add_point(KIND_SPARE, COORD_MIN, COORD_MIN, COORD_MIN, 31'd0, 1'b0);
      add_point(KIND_SITE, 32'sd4000000, -32'sd3276800, -32'sd9000000, 31'd0, 1'b1);
      // site kind opens the run
      add_point(KIND_SITE, COORD_MIN, COORD_MAX, 32'sd0, 31'd0, 1'b0);
      add_point(KIND_SITE, 32'sd5000000, -32'sd5000000, 32'sd9000000, 31'd0, 1'b0);
      add_point(KIND_PROTEIN, -32'sd1, 32'sd1, 32'sh5555_5555, 31'h2AAA_AAAA, 1'b1);
      // sphere crosses x only; sites stay home on x
      add_point(KIND_CENTER, 32'sd1000000, 32'sd0, 32'sd0, 31'd2276801, 1'b0);
      add_point(KIND_SITE, 32'sd3000000, 32'sd90000000, 32'sd0, 31'd0, 1'b0);
      add_point(KIND_SITE, -32'sd3276800, -32'sd90000000, COORD_MAX, 31'd0, 1'b1);

      run_phase(LEN_W'($urandom_range(1, LEN_MAX)), LEN_W'($urandom_range(1, LEN_MAX)),
                LEN_W'($urandom_range(1, LEN_MAX)), 1'b0, 1'b0);
      run_phase(LEN_MIN, LEN_MIN, LEN_MIN, 1'b1, 1'b0);
      run_phase(LEN_MAX, LEN_MAX, LEN_MAX, 1'b0, 1'b1);
      run_phase(LEN_MIN, LEN_MAX, LEN_W'($urandom_range(1, 1 << 20)), 1'b0, 1'b0);
      run_phase(LEN_W'($urandom_range(1, 1 << 24)), LEN_W'($urandom_range(1, 1 << 24)),
                LEN_W'($urandom_range(1, 1 << 24)), 1'b1, 1'b0);
      run_phase(BOX_LEN_RESET, BOX_LEN_RESET, BOX_LEN_RESET, 1'b0, 1'b0);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
